// ----- design/edit_distance_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Edit distance engine assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ede_pkg.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared widths, opcodes, payload types and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package ede_pkg;

  localparam int MaxLen = 2048;
  localparam int IdxW   = $clog2(MaxLen);
  localparam int LenW   = $clog2(MaxLen + 1);
  localparam int DistW  = 12;

  localparam logic [1:0] OpAppendA = 2'd0;
  localparam logic [1:0] OpAppendB = 2'd1;
  localparam logic [1:0] OpCompute = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol;
  } ede_in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             overflow;
  } ede_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append_a;
    logic append_b;
    logic start;
    logic row;
    logic update;
    logic emit;
  } ede_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic last_col;
    logic last_row;
  } ede_status_t;

endpackage

// ----- design/ede_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ede_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ede_ctrl.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine controller
// Input and output handshakes and the row/cell sequencing of the cost table.
// ----------------------------------------------------------------------------
module ede_ctrl
  import ede_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ede_status_t status_i,
  output ede_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRow  = 2'd1;
  localparam logic [1:0] StCell = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state_d, state_q;
  logic       out_valid_d, out_valid_q;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (opcode_i)
            OpAppendA: cmd_o.append_a = 1'b1;
            OpAppendB: cmd_o.append_b = 1'b1;
            OpCompute: begin
              cmd_o.start = 1'b1;
              // An empty string needs no table: the answer is the other length.
              state_d = (status_i.a_zero | status_i.b_zero) ? StDone : StRow;
            end
            default: ;
          endcase
        end
      end
      StRow: begin
        cmd_o.row = 1'b1;
        state_d   = StCell;
      end
      StCell: begin
        cmd_o.update = 1'b1;
        if (status_i.last_col) begin
          state_d = status_i.last_row ? StDone : StRow;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/ede_dp.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine datapath
// String stores, one-row cost store, lengths, counters and the cell update.
// ----------------------------------------------------------------------------
module ede_dp
  import ede_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ede_cmd_t    cmd_i,
  input  logic [7:0]  symbol_i,
  output ede_status_t status_o,
  output ede_out_t    out_data_o
);

  function automatic logic [LenW-1:0] min3(input logic [LenW-1:0] a,
                                           input logic [LenW-1:0] b,
                                           input logic [LenW-1:0] c);
    logic [LenW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  logic [LenW-1:0] len_a_q, len_b_q;
  logic            drop_q;
  logic [LenW-1:0] i_q, j_q;
  logic [LenW-1:0] diag_q, left_q, res_q;
  ede_out_t        out_q;

  logic [LenW-1:0] i_prev, j_prev;
  logic            a_full, b_full;
  logic [7:0]      char_a, char_b;
  logic [LenW-1:0] cost_rd, above, cell_val;
  logic [IdxW-1:0] rd_idx;

  assign i_prev = i_q - LenW'(1);
  assign j_prev = j_q - LenW'(1);
  assign a_full = (len_a_q == LenW'(MaxLen));
  assign b_full = (len_b_q == LenW'(MaxLen));
  // Row setup reads address zero, the first stored column; each cell prefetches the next column.
  assign rd_idx = cmd_i.row ? '0 : j_q[IdxW-1:0];

  ede_ram #(.Width(8), .Depth(MaxLen)) u_str_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append_a & ~a_full),
    .waddr_i (len_a_q[IdxW-1:0]),
    .wdata_i (symbol_i),
    .re_i    (cmd_i.row),
    .raddr_i (i_prev[IdxW-1:0]),
    .rdata_o (char_a)
  );

  ede_ram #(.Width(8), .Depth(MaxLen)) u_str_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append_b & ~b_full),
    .waddr_i (len_b_q[IdxW-1:0]),
    .wdata_i (symbol_i),
    .re_i    (cmd_i.row | cmd_i.update),
    .raddr_i (rd_idx),
    .rdata_o (char_b)
  );

  // Entry k holds the cost for column k+1; column zero lives in left_q at row start.
  ede_ram #(.Width(LenW), .Depth(MaxLen)) u_cost (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (j_prev[IdxW-1:0]),
    .wdata_i (cell_val),
    .re_i    (cmd_i.row | cmd_i.update),
    .raddr_i (rd_idx),
    .rdata_o (cost_rd)
  );

  // The first row is never stored beforehand; its costs are the column index.
  assign above    = (i_q == LenW'(1)) ? j_q : cost_rd;
  assign cell_val = (char_a == char_b) ? diag_q
                                       : min3(left_q, above, diag_q) + LenW'(1);

  assign status_o.a_zero   = (len_a_q == '0);
  assign status_o.b_zero   = (len_b_q == '0);
  assign status_o.last_col = (j_q == len_b_q);
  assign status_o.last_row = (i_q == len_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= '0;
      len_b_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (cmd_i.append_a) begin
        if (a_full) begin
          drop_q <= 1'b1;
        end else begin
          len_a_q <= len_a_q + LenW'(1);
        end
      end
      if (cmd_i.append_b) begin
        if (b_full) begin
          drop_q <= 1'b1;
        end else begin
          len_b_q <= len_b_q + LenW'(1);
        end
      end
      if (cmd_i.emit) begin
        len_a_q <= '0;
        len_b_q <= '0;
        drop_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      i_q   <= LenW'(1);
      res_q <= status_o.a_zero ? len_b_q : len_a_q;
    end
    if (cmd_i.row) begin
      diag_q <= i_prev;
      left_q <= i_q;
      j_q    <= LenW'(1);
    end
    if (cmd_i.update) begin
      left_q <= cell_val;
      diag_q <= above;
      if (status_o.last_col) begin
        i_q   <= i_q + LenW'(1);
        res_q <= cell_val;
      end else begin
        j_q <= j_q + LenW'(1);
      end
    end
    if (cmd_i.emit) begin
      out_q.distance <= DistW'(res_q);
      out_q.overflow <= drop_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- design/edit_distance_engine.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine
// Loads two byte strings and returns their Levenshtein distance on request.
// ----------------------------------------------------------------------------
//   Channel | Direction | Payload                  | Handshake
//   in      | input     | opcode, symbol           | in_valid_i / in_ready_o
//   out     | output    | distance, overflow       | out_valid_o / out_ready_i
//
// Appends are accepted back to back.
// A compute with strings of length n1 and n2 (both nonzero) runs a setup
// step for each row and then a step for each table cell,
// each cell reading the next column of the cost row RAM while writing its own.
// With an empty string the compute skips the table and goes straight to the result.
// Input is stalled during a compute and while its result waits for the output
// register; appends are taken even while an earlier result is still pending.
// Reset clears lengths, the drop flag and the control state; no clearing pass.
`include "edit_distance_engine_macros.svh"

module edit_distance_engine
  import ede_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ede_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ede_out_t out_data_o
);

  ede_cmd_t    cmd;
  ede_status_t status;

  ede_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ede_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .symbol_i   (in_data_i.symbol),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  `EDE_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd), "controller issued overlapping commands")
  `EDE_ASSERT_SAME(a_busy_no_input, cmd.row || cmd.update, !in_ready_o, "input taken during compute")
  `EDE_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_o, "result loaded but not presented")
  `EDE_ASSERT_NEXT(a_start_row, cmd.start && !status.a_zero && !status.b_zero, cmd.row,
                   "nonempty compute did not begin a row")

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Loads pairs of byte strings into the engine, requests the distance and
// compares every returned result with a Levenshtein predictor kept in step
// with the accepted input transactions. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ede_pkg::*;

  localparam logic [1:0] OpIgnored  = 2'd3;
  localparam int         CycleLimit = 1_000_000;
  localparam int         RandomGoal = 1000;

  // Predicts the engine's result from the transactions it has accepted.
  class distance_scoreboard;
    logic [7:0] first_text [MaxLen];
    logic [7:0] second_text [MaxLen];
    int         first_len;
    int         second_len;
    bit         dropped;
    ede_out_t   expected_results [$];
    int         loaded;
    int         results_seen;
    int         mismatches;
    int         longest;

    function int unsigned levenshtein();
      int unsigned row [MaxLen+1];
      int unsigned diag;
      int unsigned above;
      int unsigned best;
      for (int j = 0; j <= second_len; j++) row[j] = j;
      for (int i = 1; i <= first_len; i++) begin
        diag   = row[0];
        row[0] = i;
        for (int j = 1; j <= second_len; j++) begin
          above = row[j];
          if (first_text[i-1] == second_text[j-1]) begin
            row[j] = diag;
          end else begin
            best = row[j-1];
            if (above < best) best = above;
            if (diag < best) best = diag;
            row[j] = best + 1;
          end
          diag = above;
        end
      end
      return row[second_len];
    endfunction

    function void note_item(ede_in_t item);
      ede_out_t    res;
      int unsigned predicted;
      if (item.opcode != OpIgnored) loaded++;
      case (item.opcode)
        OpAppendA: begin
          if (first_len < MaxLen) begin
            first_text[first_len] = item.symbol;
            first_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        OpAppendB: begin
          if (second_len < MaxLen) begin
            second_text[second_len] = item.symbol;
            second_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        OpCompute: begin
          if (first_len > longest) longest = first_len;
          if (second_len > longest) longest = second_len;
          predicted = levenshtein();
          if (predicted > (1 << DistW) - 1) predicted = (1 << DistW) - 1;
          res.distance = predicted[DistW-1:0];
          res.overflow = dropped;
          expected_results.insert(expected_results.size(), res);
          first_len  = 0;
          second_len = 0;
          dropped    = 1'b0;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t ns: %s", $time, what);
    endfunction

    function void check_result(ede_out_t got);
      ede_out_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result distance=%0d overflow=%0b",
                                got.distance, got.overflow));
        return;
      end
      want = expected_results.pop_front();
      if (got.distance !== want.distance)
        note_mismatch($sformatf("result %0d distance expected %0d got %0d",
                                results_seen, want.distance, got.distance));
      if (got.overflow !== want.overflow)
        note_mismatch($sformatf("result %0d overflow expected %0b got %0b",
                                results_seen, want.overflow, got.overflow));
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ede_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ede_out_t out_data_o;

  distance_scoreboard board = new();

  int send_idle_pct = 23;
  int recv_idle_pct = 65;
  int stall_request = 0;
  int stall_left    = 0;
  int cycles        = 0;

  bit       out_fire;
  ede_out_t out_seen;

  edit_distance_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, board.expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: sample at the falling edge, check on the rising edge that
  // completes the transaction, then choose the next ready value.
  always begin
    @(negedge clk_i);
    out_fire = rst_ni && out_valid_o && out_ready_i;
    out_seen = out_data_o;
    @(posedge clk_i);
    if (out_fire) board.check_result(out_seen);
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_request > 0) begin
      stall_left    = stall_request - 1;
      stall_request = 0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called just after a rising edge; returns at the edge that accepts the item.
  task automatic send_item(input ede_in_t item);
    bit ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end
    board.note_item(item);
  endtask

  // Interleaves appends to both strings, sprinkles unused opcodes, then computes.
  task automatic send_strings(input int len_a, input int len_b, input bit narrow);
    ede_in_t item;
    int      left_a;
    int      left_b;
    left_a = len_a;
    left_b = len_b;
    while (left_a + left_b > 0) begin
      if ($urandom_range(19) == 0) begin
        item.opcode = OpIgnored;
        item.symbol = 8'($urandom);
        send_item(item);
      end
      if (left_b == 0 || (left_a > 0 && $urandom_range(1) == 1)) begin
        item.opcode = OpAppendA;
        left_a--;
      end else begin
        item.opcode = OpAppendB;
        left_b--;
      end
      item.symbol = narrow ? 8'h61 + 8'($urandom_range(3)) : 8'($urandom);
      send_item(item);
    end
    item.opcode = OpCompute;
    item.symbol = 8'($urandom);
    send_item(item);
  endtask

  task automatic send_random_pairs(input int goal);
    int len_a;
    int len_b;
    while (board.loaded < goal) begin
      len_a = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      len_b = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      send_strings(len_a, len_b, $urandom_range(2) != 0);
    end
  endtask

  initial begin
    int start;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both strings empty, then each side empty in turn.
    send_item('{OpCompute, 8'h00});
    send_item('{OpAppendA, 8'h6B});
    send_item('{OpCompute, 8'hFF});
    send_item('{OpAppendB, 8'h78});
    send_item('{OpIgnored, 8'hFF});
    send_item('{OpAppendB, 8'h79});
    send_item('{OpCompute, 8'h00});
    // Extreme symbol values, swapped between the strings.
    send_item('{OpAppendA, 8'h00});
    send_item('{OpAppendA, 8'hFF});
    send_item('{OpAppendB, 8'hFF});
    send_item('{OpAppendB, 8'h00});
    send_item('{OpCompute, 8'h5A});
    // One substitution in the middle; the symbol on compute must be ignored.
    send_item('{OpAppendA, 8'h61});
    send_item('{OpAppendB, 8'h61});
    send_item('{OpAppendA, 8'h62});
    send_item('{OpAppendB, 8'h78});
    send_item('{OpAppendA, 8'h63});
    send_item('{OpIgnored, 8'h00});
    send_item('{OpAppendB, 8'h63});
    send_item('{OpCompute, 8'hFF});
    // An unused opcode alone leaves nothing to compute.
    send_item('{OpIgnored, 8'hA5});
    send_item('{OpCompute, 8'h00});

    // A first string one past capacity drops a character and sets the
    // overflow flag; the empty compute after it shows the flag cleared.
    send_strings(MaxLen + 1, 4, 1'b1);
    send_item('{OpCompute, 8'h00});

    start = board.loaded;
    send_random_pairs(start + RandomGoal / 6);
    stall_request = 250;
    send_random_pairs(start + RandomGoal / 3);

    send_idle_pct = 65;
    recv_idle_pct = 23;
    send_random_pairs(start + 2 * RandomGoal / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 400;
    send_random_pairs(start + RandomGoal);
    in_valid_i <= 1'b0;

    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Loaded %0d transactions and checked %0d distances, strings up to %0d bytes.",
             board.loaded, board.results_seen, board.longest);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             board.mismatches, board.expected_results.size());
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
